[rtl/pmi_pkg.sv]
package pmi_pkg;

    localparam int MAX_SAMPLES_DEF = 65536;

    localparam int SMP_W     = 32;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 1;
    localparam int FV_W      = 40;
    localparam int ZP_W      = 32;
    localparam int IDX_OUT_W = 16;

    localparam int FN_W   = 34;
    localparam int Q_W    = 17;
    localparam int FRAC_Z = 16;
    localparam int FRAC_F = 10;
    localparam int FV_FRAC = 8;

    localparam int DIV_NUM_W = 50;
    localparam int DIV_DEN_W = FN_W;

    localparam logic [CFG_IDX_W-1:0] REG_Z_START = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_Z_STEP  = 1'd1;

    typedef struct packed {
        logic signed [SMP_W-1:0] prev_val;
        logic signed [SMP_W-1:0] min_val;
        logic signed [SMP_W-1:0] next_val;
    } pmi_pts_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_BASE,
        ST_DIV,
        ST_QSIGN,
        ST_MUL_Q,
        ST_ZRND,
        ST_FRND,
        ST_FADD,
        ST_DONE
    } pmi_state_t;

endpackage

[rtl/parabolic_minimum_interpolator.sv]
// Finds the minimum of a stream of equally spaced samples and refines it with a
// three-point parabola fit. Samples are taken one per cycle until the item marked
// last; the block then drops s_ready while it computes the result: prep, base and
// done when the minimum lies at an end of the array; when the fit is used, also the
// bit-serial divider for the vertex offset and passes through one shared multiplier
// and rounding adder. The result waits in an output register, so the next array may
// stream in before it is taken. The user must write z_start and z_step through the
// cfg port while no array is in progress; the block does not enforce it.
module parabolic_minimum_interpolator
    import pmi_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,

    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic signed [SMP_W-1:0] s_sample,
    input  logic                    s_last,

    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [FV_W-1:0]  m_fmin_value,
    output logic signed [ZP_W-1:0]  m_zmin_pos,
    output logic [IDX_OUT_W-1:0]    m_min_index,
    output logic                    m_interpolated,

    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_W-1:0]        cfg_data
);

    localparam int IDX_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int MA_W  = (IDX_W + 1 > Q_W) ? IDX_W + 1 : Q_W;
    localparam int PW    = MA_W + FN_W;
    localparam int AW    = PW + 2;
    localparam int MI_W  = (IDX_W > IDX_OUT_W) ? IDX_W : IDX_OUT_W;

    localparam logic signed [PW:0] HALF_Z = (PW+1)'(2 ** (FRAC_Z - 1));
    localparam logic signed [PW:0] HALF_F = (PW+1)'(2 ** (FRAC_F - 1));
    localparam logic signed [AW-1:0] ZP_MAX = AW'(64'sh7FFF_FFFF);
    localparam logic signed [AW-1:0] ZP_MIN = AW'(-64'sh8000_0000);
    localparam logic signed [AW-1:0] FV_MAX = AW'(64'sh7F_FFFF_FFFF);
    localparam logic signed [AW-1:0] FV_MIN = AW'(-64'sh80_0000_0000);

    pmi_state_t state_reg, state_next;

    logic signed [CFG_W-1:0] z_start_reg, z_step_reg;

    logic signed [FN_W-1:0] n_reg, n_next;
    logic signed [FN_W-1:0] d_reg, d_next;
    logic signed [PW-1:0]   prod_reg, prod_next;
    logic signed [PW-1:0]   rnd_reg, rnd_next;
    logic signed [AW-1:0]   zp_reg, zp_next;
    logic signed [AW-1:0]   fv_reg, fv_next;
    logic signed [Q_W-1:0]  q_reg, q_next;
    logic                   interp_reg, interp_next;

    logic                   m_valid_reg, m_valid_next;
    logic signed [FV_W-1:0] fv_out_reg, fv_out_next;
    logic signed [ZP_W-1:0] zp_out_reg, zp_out_next;
    logic [IDX_OUT_W-1:0]   idx_out_reg, idx_out_next;
    logic                   interp_out_reg, interp_out_next;

    pmi_pts_t         pts;
    logic [IDX_W-1:0] min_idx;
    logic             trk_interp;
    logic             trk_clear;
    logic             s_accept;

    logic                 div_start;
    logic                 div_done;
    logic [Q_W-1:0]       div_quo;
    logic [FN_W-2:0]      n_abs;
    logic [DIV_NUM_W-1:0] div_num;
    logic [DIV_DEN_W-1:0] div_den;

    logic signed [MA_W-1:0] mul_a;
    logic signed [FN_W-1:0] mul_b;
    logic signed [PW-1:0]   mul_p;
    logic signed [PW:0]     rnd_ext;
    logic signed [PW:0]     rnd_bias;
    logic signed [PW:0]     rnd_sum;
    logic [MI_W-1:0]        idx_ext;

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_accept  = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    pmi_tracker #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .IDX_W       (IDX_W)
    ) u_tracker (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (s_accept),
        .sample  (s_sample),
        .clear   (trk_clear),
        .pts     (pts),
        .min_idx (min_idx),
        .interp  (trk_interp)
    );

    assign n_abs   = n_reg[FN_W-1] ? (FN_W-1)'(-n_reg) : n_reg[FN_W-2:0];
    assign div_num = DIV_NUM_W'({n_abs, {FRAC_Z{1'b0}}}) + DIV_NUM_W'(d_reg[FN_W-2:0]);
    assign div_den = {d_reg[FN_W-2:0], 1'b0};

    pmi_divider u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quo     (div_quo)
    );

    // shared multiplier and round-to-nearest (ties away from zero)
    always_comb begin
        case (state_reg)
            ST_PREP: begin
                mul_a = MA_W'(min_idx);
                mul_b = FN_W'(z_step_reg);
            end
            ST_ZRND: begin
                mul_a = MA_W'(q_reg);
                mul_b = n_reg;
            end
            default: begin
                mul_a = MA_W'(q_reg);
                mul_b = FN_W'(z_step_reg);
            end
        endcase
        mul_p   = mul_a * mul_b;
        rnd_ext = (PW+1)'(prod_reg);
        if (state_reg == ST_ZRND) begin
            rnd_bias = prod_reg[PW-1] ? HALF_Z - (PW+1)'(1) : HALF_Z;
        end else begin
            rnd_bias = prod_reg[PW-1] ? HALF_F - (PW+1)'(1) : HALF_F;
        end
        rnd_sum = rnd_ext + rnd_bias;
        idx_ext = MI_W'(min_idx);
    end

    always_comb begin
        state_next      = state_reg;
        n_next          = n_reg;
        d_next          = d_reg;
        prod_next       = prod_reg;
        rnd_next        = rnd_reg;
        zp_next         = zp_reg;
        fv_next         = fv_reg;
        q_next          = q_reg;
        interp_next     = interp_reg;
        div_start       = 1'b0;
        trk_clear       = 1'b0;
        m_valid_next    = m_valid_reg && !m_ready;
        fv_out_next     = fv_out_reg;
        zp_out_next     = zp_out_reg;
        idx_out_next    = idx_out_reg;
        interp_out_next = interp_out_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept && s_last) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                n_next      = FN_W'(pts.prev_val) - FN_W'(pts.next_val);
                d_next      = FN_W'(pts.prev_val) - (FN_W'(pts.min_val) <<< 1)
                            + FN_W'(pts.next_val);
                prod_next   = mul_p;
                interp_next = trk_interp;
                state_next  = ST_BASE;
            end
            ST_BASE: begin
                zp_next   = AW'(z_start_reg) + AW'(prod_reg);
                fv_next   = AW'(pts.min_val) <<< FV_FRAC;
                div_start = interp_reg;
                state_next = interp_reg ? ST_DIV : ST_DONE;
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_QSIGN;
                end
            end
            ST_QSIGN: begin
                q_next     = n_reg[FN_W-1] ? -signed'(div_quo) : signed'(div_quo);
                state_next = ST_MUL_Q;
            end
            ST_MUL_Q: begin
                prod_next  = mul_p;
                state_next = ST_ZRND;
            end
            ST_ZRND: begin
                rnd_next   = PW'(rnd_sum >>> FRAC_Z);
                prod_next  = mul_p;
                state_next = ST_FRND;
            end
            ST_FRND: begin
                zp_next    = zp_reg + AW'(rnd_reg);
                rnd_next   = PW'(rnd_sum >>> FRAC_F);
                state_next = ST_FADD;
            end
            ST_FADD: begin
                fv_next    = fv_reg - AW'(rnd_reg);
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    if (fv_reg > FV_MAX) begin
                        fv_out_next = FV_MAX[FV_W-1:0];
                    end else if (fv_reg < FV_MIN) begin
                        fv_out_next = FV_MIN[FV_W-1:0];
                    end else begin
                        fv_out_next = fv_reg[FV_W-1:0];
                    end
                    if (zp_reg > ZP_MAX) begin
                        zp_out_next = ZP_MAX[ZP_W-1:0];
                    end else if (zp_reg < ZP_MIN) begin
                        zp_out_next = ZP_MIN[ZP_W-1:0];
                    end else begin
                        zp_out_next = zp_reg[ZP_W-1:0];
                    end
                    idx_out_next    = idx_ext[IDX_OUT_W-1:0];
                    interp_out_next = interp_reg;
                    trk_clear       = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            interp_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            interp_reg  <= interp_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            z_start_reg <= '0;
            z_step_reg  <= CFG_W'(65536);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_Z_START: z_start_reg <= cfg_data;
                REG_Z_STEP:  z_step_reg  <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        n_reg          <= n_next;
        d_reg          <= d_next;
        prod_reg       <= prod_next;
        rnd_reg        <= rnd_next;
        zp_reg         <= zp_next;
        fv_reg         <= fv_next;
        q_reg          <= q_next;
        fv_out_reg     <= fv_out_next;
        zp_out_reg     <= zp_out_next;
        idx_out_reg    <= idx_out_next;
        interp_out_reg <= interp_out_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_fmin_value   = fv_out_reg;
    assign m_zmin_pos     = zp_out_reg;
    assign m_min_index    = idx_out_reg;
    assign m_interpolated = interp_out_reg;

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg) == ST_DONE)
        else $error("result raised outside the done state");

    a_last_starts_calc: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_last |=> state_reg == ST_PREP)
        else $error("last item did not start the calculation");

    a_div_to_qsign: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_QSIGN |-> $past(state_reg) == ST_DIV && $past(div_done))
        else $error("quotient used before the divider finished");

    a_div_only_fit: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIV |-> interp_reg)
        else $error("divider run for an end-point minimum");

endmodule

[rtl/pmi_tracker.sv]
module pmi_tracker
    import pmi_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
    parameter int IDX_W       = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    accept,
    input  logic signed [SMP_W-1:0] sample,
    input  logic                    clear,
    output pmi_pts_t                pts,
    output logic [IDX_W-1:0]        min_idx,
    output logic                    interp
);

    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);

    logic signed [SMP_W-1:0] min_reg, min_next;
    logic signed [SMP_W-1:0] prev_min_reg, prev_min_next;
    logic signed [SMP_W-1:0] next_min_reg, next_min_next;
    logic signed [SMP_W-1:0] last_smp_reg, last_smp_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    await_reg, await_next;

    always_comb begin
        min_next      = min_reg;
        prev_min_next = prev_min_reg;
        next_min_next = next_min_reg;
        last_smp_next = last_smp_reg;
        idx_next      = idx_reg;
        cnt_next      = cnt_reg;
        await_next    = await_reg;
        if (clear) begin
            min_next      = '0;
            prev_min_next = '0;
            next_min_next = '0;
            last_smp_next = '0;
            idx_next      = '0;
            cnt_next      = '0;
            await_next    = 1'b0;
        end else if (accept && (cnt_reg < CNT_W'(MAX_SAMPLES))) begin
            if ((cnt_reg == '0) || (sample < min_reg)) begin
                min_next      = sample;
                idx_next      = IDX_W'(cnt_reg);
                prev_min_next = last_smp_reg;
                await_next    = 1'b1;
            end else if (await_reg) begin
                next_min_next = sample;
                await_next    = 1'b0;
            end
            last_smp_next = sample;
            cnt_next      = cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_reg      <= '0;
            prev_min_reg <= '0;
            next_min_reg <= '0;
            last_smp_reg <= '0;
            idx_reg      <= '0;
            cnt_reg      <= '0;
            await_reg    <= 1'b0;
        end else begin
            min_reg      <= min_next;
            prev_min_reg <= prev_min_next;
            next_min_reg <= next_min_next;
            last_smp_reg <= last_smp_next;
            idx_reg      <= idx_next;
            cnt_reg      <= cnt_next;
            await_reg    <= await_next;
        end
    end

    assign pts.prev_val = prev_min_reg;
    assign pts.min_val  = min_reg;
    assign pts.next_val = next_min_reg;
    assign min_idx      = idx_reg;
    assign interp       = (idx_reg != '0) && (CNT_W'(idx_reg) != (cnt_reg - CNT_W'(1)));

endmodule

[rtl/pmi_divider.sv]
module pmi_divider
    import pmi_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [DIV_NUM_W-1:0] num,
    input  logic [DIV_DEN_W-1:0] den,
    output logic                 done,
    output logic [Q_W-1:0]       quo
);

    localparam int CNT_W = $clog2(Q_W);

    logic [DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [Q_W-1:0]       sh_reg, sh_next;
    logic [Q_W-1:0]       quo_reg, quo_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic [DIV_DEN_W:0]   trial;
    logic                 qbit;

    always_comb begin
        rem_next  = rem_reg;
        sh_next   = sh_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {rem_reg, sh_reg[Q_W-1]};
        qbit      = trial >= {1'b0, den};
        if (start) begin
            rem_next  = DIV_DEN_W'(num[DIV_NUM_W-1:Q_W]);
            sh_next   = num[Q_W-1:0];
            quo_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = qbit ? DIV_DEN_W'(trial - {1'b0, den}) : trial[DIV_DEN_W-1:0];
            sh_next  = {sh_reg[Q_W-2:0], 1'b0};
            quo_next = {quo_reg[Q_W-2:0], qbit};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(Q_W - 1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        sh_reg  <= sh_next;
        quo_reg <= quo_next;
    end

    assign done = busy_reg && (cnt_reg == CNT_W'(Q_W - 1));
    assign quo  = quo_reg;

endmodule

[dv/tb_parabolic_minimum_interpolator.sv]
module tb_parabolic_minimum_interpolator;
    import pmi_pkg::*;

    localparam longint S_MAX  = 64'sd2147483647;
    localparam longint S_MIN  = -64'sd2147483648;
    localparam longint FV_MAX = (64'sd1 <<< 39) - 1;
    localparam longint FV_MIN = -(64'sd1 <<< 39);

    typedef struct {
        logic signed [FV_W-1:0]  fv;
        logic signed [ZP_W-1:0]  zp;
        logic [IDX_OUT_W-1:0]    idx;
        logic                    interp;
    } minimum_t;

    class vertex_tracker;
        longint      z_start;
        longint      z_step;
        longint      cur_min;
        longint      before_min;
        longint      after_min;
        longint      prev_smp;
        int unsigned min_idx;
        int unsigned count;
        bit          want_after;
        minimum_t    pending[$];
        int          errors;

        function new();
            z_start = 0;
            z_step  = 65536;
            errors  = 0;
            clear();
        endfunction

        function void clear();
            cur_min    = 0;
            before_min = 0;
            after_min  = 0;
            prev_smp   = 0;
            min_idx    = 0;
            count      = 0;
            want_after = 0;
        endfunction

        // nearest, ties away from zero; den > 0
        static function longint div_nearest(longint num, longint den);
            longint mag;
            longint r;
            mag = (num < 0) ? -num : num;
            r = (mag + den / 2) / den;
            return (num < 0) ? -r : r;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            if (idx == REG_Z_START) begin
                z_start = longint'(signed'(data));
            end else if (idx == REG_Z_STEP) begin
                z_step = longint'(signed'(data));
            end
        endfunction

        function void take_sample(logic signed [SMP_W-1:0] smp, logic lst);
            longint      s;
            longint      n;
            longint      d;
            longint      q;
            longint      fv;
            longint      zp;
            int unsigned last_idx;
            minimum_t    m;
            s = smp;
            if (count < MAX_SAMPLES_DEF) begin
                if (count == 0 || s < cur_min) begin
                    cur_min    = s;
                    min_idx    = count;
                    before_min = prev_smp;
                    want_after = 1;
                end else if (want_after) begin
                    after_min  = s;
                    want_after = 0;
                end
                prev_smp = s;
                count++;
            end
            if (!lst) return;
            last_idx = count - 1;
            zp = z_start + longint'(min_idx) * z_step;
            m.interp = (min_idx != 0 && min_idx != last_idx);
            if (!m.interp) begin
                fv = cur_min * 256;
            end else begin
                n  = before_min - after_min;
                d  = before_min - 2 * cur_min + after_min;
                q  = div_nearest(n * 65536, 2 * d);
                zp = zp + div_nearest(q * z_step, 65536);
                fv = cur_min * 256 - div_nearest(n * q, 1024);
            end
            if (fv < FV_MIN) fv = FV_MIN;
            if (fv > FV_MAX) fv = FV_MAX;
            if (zp < S_MIN) zp = S_MIN;
            if (zp > S_MAX) zp = S_MAX;
            m.fv  = fv[FV_W-1:0];
            m.zp  = zp[ZP_W-1:0];
            m.idx = min_idx[IDX_OUT_W-1:0];
            pending.push_back(m);
            clear();
        endfunction

        function void check_minimum(logic signed [FV_W-1:0] fv, logic signed [ZP_W-1:0] zp,
                                    logic [IDX_OUT_W-1:0] idx, logic interp);
            minimum_t m;
            if (pending.size() == 0) begin
                $display("%0t: unexpected item fmin=%0d zmin=%0d idx=%0d interp=%0b",
                         $time, fv, zp, idx, interp);
                errors++;
                return;
            end
            m = pending.pop_front();
            if (fv !== m.fv) begin
                $display("%0t: fmin_value expected %0d actual %0d", $time, m.fv, fv);
                errors++;
            end
            if (zp !== m.zp) begin
                $display("%0t: zmin_pos expected %0d actual %0d", $time, m.zp, zp);
                errors++;
            end
            if (idx !== m.idx) begin
                $display("%0t: min_index expected %0d actual %0d", $time, m.idx, idx);
                errors++;
            end
            if (interp !== m.interp) begin
                $display("%0t: interpolated expected %0b actual %0b", $time, m.interp, interp);
                errors++;
            end
        endfunction
    endclass

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic signed [SMP_W-1:0] s_sample = '0;
    logic                    s_last = 1'b0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic signed [FV_W-1:0]  m_fmin_value;
    logic signed [ZP_W-1:0]  m_zmin_pos;
    logic [IDX_OUT_W-1:0]    m_min_index;
    logic                    m_interpolated;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index = REG_Z_START;
    logic [CFG_W-1:0]        cfg_data = '0;

    vertex_tracker tracker = new();

    logic signed [SMP_W-1:0] dir_smp [23] = '{
        5, 32'sh7FFFFFFF, 32'sh80000000,
        3, 1, 2,
        32'sh7FFFFFFF, 32'sh80000000, 32'sh80000001,
        32'sh80000000, 32'sh80000000, 0,
        0, 0, -1,
        10, 4, 4, 7,
        4, 7, 4, 9
    };
    bit dir_last [23] = '{
        1, 1, 1,
        0, 0, 1,
        0, 0, 1,
        0, 0, 1,
        0, 0, 1,
        0, 0, 0, 1,
        0, 0, 0, 1
    };

    parabolic_minimum_interpolator uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sample       (s_sample),
        .s_last         (s_last),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_fmin_value   (m_fmin_value),
        .m_zmin_pos     (m_zmin_pos),
        .m_min_index    (m_min_index),
        .m_interpolated (m_interpolated),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic push_sample(input logic signed [SMP_W-1:0] smp, input logic lst,
                               input int gap);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid  = 1'b1;
        s_sample = smp;
        s_last   = lst;
        do @(posedge aclk); while (s_ready !== 1'b1);
        tracker.take_sample(smp, lst);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        tracker.write_reg(idx, data);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_valid = 1'b0;
        while (tracker.pending.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic run_arrays(input int n_items);
        int     sent;
        int     len;
        int     mode;
        int     c;
        int     gap;
        longint a;
        longint base;
        longint v;
        bit     burst;
        sent = 0;
        while (sent < n_items) begin
            len   = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 120) : $urandom_range(1, 24);
            mode  = $urandom_range(0, 3);
            c     = $urandom_range(0, len - 1);
            a     = $urandom_range(1, 65536);
            base  = longint'($signed($urandom)) >>> $urandom_range(0, 16);
            burst = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < len; i++) begin
                case (mode)
                    0: v = longint'($signed($urandom));
                    1: v = base + a * (i - c) * (i - c) + $urandom_range(0, 3);
                    2: v = longint'($urandom_range(0, 6)) - 3;
                    default: begin
                        case ($urandom_range(0, 4))
                            0: v = S_MIN;
                            1: v = S_MAX;
                            2: v = 0;
                            3: v = -1;
                            default: v = longint'($signed($urandom));
                        endcase
                    end
                endcase
                if (v > S_MAX) v = S_MAX;
                if (v < S_MIN) v = S_MIN;
                gap = burst ? 0 : $urandom_range(0, 18);
                push_sample(v[SMP_W-1:0], i == len - 1, gap);
            end
            sent += len;
        end
    endtask

    initial begin
        bit quiet;
        int gap;
        quiet = 0;
        wait (aresetn === 1'b1);
        forever begin
            if ($urandom_range(0, 7) == 0) quiet = !quiet;
            gap = quiet ? 0 : $urandom_range(0, 18);
            @(negedge aclk);
            if (gap > 0) begin
                m_ready = 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready = 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
            tracker.check_minimum(m_fmin_value, m_zmin_pos, m_min_index, m_interpolated);
        end
    end

    initial begin
        logic [CFG_W-1:0] zs;
        logic [CFG_W-1:0] zt;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        for (int i = 0; i < 23; i++) begin
            push_sample(dir_smp[i], dir_last[i], $urandom_range(0, 18));
        end
        wait_drained();

        for (int p = 0; p < 5; p++) begin
            case (p)
                0: begin zs = 32'h7FFFFFFF; zt = 32'h7FFFFFFF; end
                1: begin zs = 32'h80000000; zt = 32'h80000000; end
                2: begin zs = $urandom; zt = '0; end
                3: begin zs = $urandom; zt = $urandom_range(0, 1 << 21) - (1 << 20); end
                default: begin zs = $urandom; zt = $urandom; end
            endcase
            write_cfg(REG_Z_START, zs);
            write_cfg(REG_Z_STEP, zt);
            run_arrays(190);
            wait_drained();
        end

        if (tracker.errors == 0 && tracker.pending.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #10000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
